### rtl/core/wmf_pkg.sv
// ----------------------------------------------------------------------------
// wmf_pkg
// Shared types and constants of the window median filter.
// ----------------------------------------------------------------------------
package wmf_pkg;

	localparam int MAX_ROW_PIXELS_DEF = 1024;
	localparam int MAX_RADIUS_DEF     = 3;
	localparam int CHANNELS_DEF       = 3;

	localparam int CH_W   = 8;
	localparam int PIX_W  = 24;
	localparam int OUT_CH = 3;

	localparam logic [9:0]  WIDTH_RST    = 10'd640;
	localparam logic [12:0] HEIGHT_RST   = 13'd480;
	localparam logic [1:0]  RAD_ROWS_RST = 2'd1;
	localparam logic [1:0]  RAD_COLS_RST = 2'd1;
	localparam logic [1:0]  CHAN_RST     = 2'd3;

	localparam logic [12:0] ROW_SAT = 13'h1FFF;

	typedef enum logic [2:0] {
		REG_WIDTH    = 3'd0,
		REG_HEIGHT   = 3'd1,
		REG_RAD_ROWS = 3'd2,
		REG_RAD_COLS = 3'd3,
		REG_CHANNELS = 3'd4
	} wmf_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SELECT,
		ST_OUTPUT
	} wmf_state_t;

	typedef struct packed {
		logic       start;
		logic       step;
		logic [2:0] bit_idx;
	} wmf_lane_ctrl_t;

endpackage

### rtl/core/window_median_filter.sv
// A pixel transaction that gives no result takes an accept step with the line store read
// and a window update; one that gives a result adds eight radix selection steps in the
// channel lanes and a load into the output register, which waits on a stalled result.
// A finished result may wait in the output register while the next pixel is taken.
// Reset clears the position counters, the control state and the registers to their
// defaults; line store and window contents are undefined until written.
// ----------------------------------------------------------------------------
// window_median_filter
// Two-dimensional median filter over a padded image block in raster order.
// ----------------------------------------------------------------------------
module window_median_filter
	import wmf_pkg::*;
#(
	parameter int MAX_ROW_PIXELS = MAX_ROW_PIXELS_DEF,
	parameter int MAX_RADIUS     = MAX_RADIUS_DEF,
	parameter int CHANNELS       = CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  sample_ch0,
	input  logic [7:0]  sample_ch1,
	input  logic [7:0]  sample_ch2,
	input  logic        block_start,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  median_ch0,
	output logic [7:0]  median_ch1,
	output logic [7:0]  median_ch2,
	output logic [11:0] center_row,
	output logic [9:0]  center_col,
	output logic        block_done
);

	localparam int AW    = $clog2(MAX_ROW_PIXELS);
	localparam int WS    = 2 * MAX_RADIUS + 1;
	localparam int WN    = WS * WS;
	localparam int NB    = 2 * MAX_RADIUS;
	localparam int MW    = $clog2(NB);
	localparam int RKW   = $clog2(WN + 1);
	localparam int LANES = (CHANNELS < OUT_CH) ? CHANNELS : OUT_CH;

	logic [9:0]  width_q;
	logic [12:0] height_q;
	logic [1:0]  rad_rows_q;
	logic [1:0]  rad_cols_q;
	logic [1:0]  chan_q;

	wmf_state_t state_q, state_d;
	logic [2:0] bit_q;
	logic       accept;
	logic       out_load;

	logic [12:0]   row_q;
	logic [AW-1:0] col_q;
	logic [MW-1:0] mod_q [MAX_RADIUS];

	logic [15:0] rr, rc2, n2, w_eff, h_eff, pw, ph, wmax;
	logic [12:0] r0, r1, row_d;
	logic [15:0] c0, c1;
	logic [AW-1:0] col_d;
	logic [MW-1:0] mod0 [MAX_RADIUS];
	logic [MW-1:0] mod1 [MAX_RADIUS];
	logic [MW-1:0] mod_d [MAX_RADIUS];
	logic [MW-1:0] rm;
	logic          hit;
	logic          done_flag;

	logic [PIX_W-1:0] pix_s1;
	logic [MW-1:0]    rm_s1;
	logic             hit_s1;
	logic             done_s1;
	logic [11:0]      crow_s1;
	logic [9:0]       ccol_s1;

	logic [PIX_W-1:0] rd_data [NB];
	logic [PIX_W-1:0] colv [WS];
	logic [PIX_W-1:0] win_q [WS][WS];

	logic [WN-1:0]   init_mask;
	logic [RKW-1:0]  rank;
	wmf_lane_ctrl_t  lane_ctrl;
	logic [CH_W-1:0] lane_med [OUT_CH];

	// Configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= WIDTH_RST;
			height_q   <= HEIGHT_RST;
			rad_rows_q <= RAD_ROWS_RST;
			rad_cols_q <= RAD_COLS_RST;
			chan_q     <= CHAN_RST;
		end else if (psel && penable && pwrite) begin
			unique case (wmf_reg_t'(paddr[4:2]))
				REG_WIDTH:    width_q    <= pwdata[9:0];
				REG_HEIGHT:   height_q   <= pwdata[12:0];
				REG_RAD_ROWS: rad_rows_q <= pwdata[1:0];
				REG_RAD_COLS: rad_cols_q <= pwdata[1:0];
				REG_CHANNELS: chan_q     <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (wmf_reg_t'(paddr[4:2]))
			REG_WIDTH:    prdata = {22'd0, width_q};
			REG_HEIGHT:   prdata = {19'd0, height_q};
			REG_RAD_ROWS: prdata = {30'd0, rad_rows_q};
			REG_RAD_COLS: prdata = {30'd0, rad_cols_q};
			REG_CHANNELS: prdata = {30'd0, chan_q};
			default:      prdata = '0;
		endcase
	end

	// Effective geometry
	always_comb begin
		rr    = (int'(rad_rows_q) > MAX_RADIUS) ? 16'(MAX_RADIUS) : 16'(rad_rows_q);
		rc2   = (int'(rad_cols_q) > MAX_RADIUS) ? 16'(2 * MAX_RADIUS) : 16'({rad_cols_q, 1'b0});
		n2    = {rr[14:0], 1'b0};
		wmax  = 16'(MAX_ROW_PIXELS) - rc2;
		w_eff = (width_q == '0) ? 16'd1 : 16'(width_q);
		if (w_eff > wmax) begin
			w_eff = wmax;
		end
		h_eff = (height_q == '0) ? 16'd1 : 16'(height_q);
		if (h_eff > 16'd4096) begin
			h_eff = 16'd4096;
		end
		pw = w_eff + rc2;
		ph = h_eff + n2;
	end

	// Position tracking
	always_comb begin
		r0 = block_start ? '0 : row_q;
		c0 = block_start ? '0 : 16'(col_q);
		for (int d = 0; d < MAX_RADIUS; d++) begin
			mod0[d] = block_start ? '0 : mod_q[d];
		end
		r1 = r0;
		c1 = c0;
		for (int d = 0; d < MAX_RADIUS; d++) begin
			mod1[d] = mod0[d];
		end
		if (c0 >= pw) begin
			c1 = '0;
			if (r0 != ROW_SAT) begin
				r1 = r0 + 13'd1;
				for (int d = 0; d < MAX_RADIUS; d++) begin
					mod1[d] = (int'(mod0[d]) + 1 == 2 * (d + 1)) ? '0 : MW'(int'(mod0[d]) + 1);
				end
			end
		end
		rm = '0;
		for (int d = 0; d < MAX_RADIUS; d++) begin
			if (int'(rr) == d + 1) begin
				rm = mod1[d];
			end
		end
		row_d = r1;
		for (int d = 0; d < MAX_RADIUS; d++) begin
			mod_d[d] = mod1[d];
		end
		if (c1 + 16'd1 >= pw) begin
			col_d = '0;
			if (r1 != ROW_SAT) begin
				row_d = r1 + 13'd1;
				for (int d = 0; d < MAX_RADIUS; d++) begin
					mod_d[d] = (int'(mod1[d]) + 1 == 2 * (d + 1)) ? '0 : MW'(int'(mod1[d]) + 1);
				end
			end
		end else begin
			col_d = AW'(c1 + 16'd1);
		end
		hit       = (16'(r1) >= n2) && (c1 >= rc2) && (16'(r1) < ph);
		done_flag = (16'(r1) == ph - 16'd1) && (c1 == pw - 16'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			for (int d = 0; d < MAX_RADIUS; d++) begin
				mod_q[d] <= '0;
			end
		end else if (accept) begin
			row_q <= row_d;
			col_q <= col_d;
			for (int d = 0; d < MAX_RADIUS; d++) begin
				mod_q[d] <= mod_d[d];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= 1'b0;
		end else if (accept) begin
			hit_s1 <= hit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= {sample_ch2, sample_ch1, sample_ch0};
			rm_s1   <= rm;
			done_s1 <= done_flag;
			crow_s1 <= 12'(16'(r1) - n2);
			ccol_s1 <= 10'(c1 - rc2);
		end
	end

	wmf_line_store #(
		.MAX_ROW_PIXELS(MAX_ROW_PIXELS),
		.BANKS(NB)
	) u_line_store (
		.clk(clk),
		.access(accept),
		.wr_en(rr != '0),
		.wr_bank(rm),
		.addr(AW'(c1)),
		.wr_data({sample_ch2, sample_ch1, sample_ch0}),
		.rd_data(rd_data)
	);

	// Window column and window registers
	always_comb begin
		int sum;
		for (int k = 0; k < WS; k++) begin
			sum = int'(rm_s1) + k;
			if (sum >= int'(n2)) begin
				sum = sum - int'(n2);
			end
			if (k < int'(n2)) begin
				colv[k] = rd_data[MW'(sum)];
			end else begin
				colv[k] = pix_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			for (int k = 0; k < WS; k++) begin
				for (int j = 0; j < WS; j++) begin
					if (k <= int'(n2)) begin
						if (j < int'(rc2)) begin
							win_q[k][j] <= win_q[k][(j + 1) % WS];
						end else if (j == int'(rc2)) begin
							win_q[k][j] <= colv[k];
						end
					end
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < WN; i++) begin
			init_mask[i] = ((i / WS) <= int'(n2)) && ((i % WS) <= int'(rc2));
		end
		rank = RKW'(((int'(n2) + 1) * (int'(rc2) + 1)) >> 1);
	end

	// Channel lanes
	for (genvar l = 0; l < OUT_CH; l++) begin : g_lane
		if (l < LANES) begin : g_on
			logic [CH_W-1:0] vals [WN];
			for (genvar i = 0; i < WN; i++) begin : g_tap
				assign vals[i] = win_q[i / WS][i % WS][CH_W*l +: CH_W];
			end
			wmf_select_lane #(
				.WN(WN)
			) u_lane (
				.clk(clk),
				.arst_n(arst_n),
				.ctrl(lane_ctrl),
				.vals(vals),
				.init_mask(init_mask),
				.rank(rank),
				.median(lane_med[l])
			);
		end else begin : g_off
			assign lane_med[l] = '0;
		end
	end

	// Sequencer
	assign accept   = in_valid && !in_stall;
	assign out_load = (state_q == ST_OUTPUT) && (!out_valid || !out_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_LOAD;
			ST_LOAD:   state_d = hit_s1 ? ST_SELECT : ST_IDLE;
			ST_SELECT: if (bit_q == 3'd0) state_d = ST_OUTPUT;
			ST_OUTPUT: if (!out_valid || !out_stall) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall          = 1'b1;
		lane_ctrl.start   = 1'b0;
		lane_ctrl.step    = 1'b0;
		lane_ctrl.bit_idx = bit_q;
		unique case (state_q)
			ST_IDLE:   in_stall = 1'b0;
			ST_LOAD:   lane_ctrl.start = 1'b1;
			ST_SELECT: lane_ctrl.step = 1'b1;
			ST_OUTPUT: ;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= 3'd7;
		end else begin
			state_q <= state_d;
			if (state_q == ST_LOAD) begin
				bit_q <= 3'd7;
			end else if (state_q == ST_SELECT) begin
				bit_q <= bit_q - 3'd1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			median_ch0 <= (chan_q > 2'd0) ? lane_med[0] : '0;
			median_ch1 <= (chan_q > 2'd1) ? lane_med[1] : '0;
			median_ch2 <= (chan_q > 2'd2) ? lane_med[2] : '0;
			center_row <= crow_s1;
			center_col <= ccol_s1;
			block_done <= done_s1;
		end
	end

endmodule

### rtl/core/wmf_line_store.sv
// ----------------------------------------------------------------------------
// wmf_line_store
// Banked row memories, one bank per stored row, read before write.
// ----------------------------------------------------------------------------
module wmf_line_store
	import wmf_pkg::*;
#(
	parameter int MAX_ROW_PIXELS = MAX_ROW_PIXELS_DEF,
	parameter int BANKS          = 2 * MAX_RADIUS_DEF
) (
	input  logic                              clk,
	input  logic                              access,
	input  logic                              wr_en,
	input  logic [$clog2(BANKS)-1:0]          wr_bank,
	input  logic [$clog2(MAX_ROW_PIXELS)-1:0] addr,
	input  logic [PIX_W-1:0]                  wr_data,
	output logic [PIX_W-1:0]                  rd_data [BANKS]
);

	for (genvar b = 0; b < BANKS; b++) begin : g_bank
		logic [PIX_W-1:0] mem [MAX_ROW_PIXELS];

		always_ff @(posedge clk) begin
			if (access) begin
				rd_data[b] <= mem[addr];
				if (wr_en && (wr_bank == b[$clog2(BANKS)-1:0])) begin
					mem[addr] <= wr_data;
				end
			end
		end
	end

endmodule

### rtl/core/wmf_select_lane.sv
// ----------------------------------------------------------------------------
// wmf_select_lane
// Bitwise rank selection of one channel over the window, one bit a cycle.
// ----------------------------------------------------------------------------
module wmf_select_lane
	import wmf_pkg::*;
#(
	parameter int WN = 49
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  wmf_lane_ctrl_t              ctrl,
	input  logic [CH_W-1:0]             vals [WN],
	input  logic [WN-1:0]               init_mask,
	input  logic [$clog2(WN+1)-1:0]     rank,
	output logic [CH_W-1:0]             median
);

	localparam int RKW = $clog2(WN + 1);

	logic [WN-1:0]   mask_q;
	logic [RKW-1:0]  rank_q;
	logic [CH_W-1:0] med_q;
	logic [WN-1:0]   bit_set;
	logic [RKW-1:0]  zero_cnt;

	always_comb begin
		zero_cnt = '0;
		for (int i = 0; i < WN; i++) begin
			bit_set[i] = vals[i][ctrl.bit_idx];
			zero_cnt   = zero_cnt + RKW'(mask_q[i] & ~bit_set[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			rank_q <= '0;
			med_q  <= '0;
		end else if (ctrl.start) begin
			mask_q <= init_mask;
			rank_q <= rank;
			med_q  <= '0;
		end else if (ctrl.step) begin
			if (rank_q < zero_cnt) begin
				mask_q <= mask_q & ~bit_set;
			end else begin
				mask_q                <= mask_q & bit_set;
				rank_q                <= rank_q - zero_cnt;
				med_q[ctrl.bit_idx]   <= 1'b1;
			end
		end
	end

	assign median = med_q;

endmodule

### rtl/core/wmf_checker.sv
// ----------------------------------------------------------------------------
// wmf_checker
// Port-level checks of the window median filter, bound to the top level.
// ----------------------------------------------------------------------------
module wmf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  median_ch0,
	input logic [11:0] center_row,
	input logic [9:0]  center_col
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("A transaction was accepted while the previous one was in work.");

	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> !$past(in_valid && !in_stall))
		else $error("Two input transactions were accepted in consecutive cycles.");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("A result appeared without a transaction in work.");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(median_ch0)
			&& $stable(center_row) && $stable(center_col))
		else $error("A stalled result transaction changed.");

endmodule

bind window_median_filter wmf_checker u_wmf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.median_ch0(median_ch0),
	.center_row(center_row),
	.center_col(center_col)
);
